// ----- src/cbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbc_pkg;

    localparam int CONTEXT_COUNT = 365;
    localparam int CTX_W         = $clog2(CONTEXT_COUNT);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [18:0] THR_SMALL = 19'sd3;
    localparam logic signed [18:0] THR_MID   = 19'sd7;
    localparam logic signed [18:0] THR_LARGE = 19'sd21;

    localparam logic signed [9:0] WEIGHT_SECOND = 10'sd9;
    localparam logic signed [9:0] WEIGHT_THIRD  = 10'sd81;

    localparam int INIT_ROUND = 32;
    localparam int INIT_SHIFT = 6;
    localparam int INIT_W     = 18 - INIT_SHIFT;
    localparam int INIT_MIN   = 2;

    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [16:0] RESET_RANGE     = 17'd256;
    localparam logic [15:0] RESET_THRESHOLD = 16'd64;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_REINIT = 2'd2;

    localparam logic REG_SAMPLE_RANGE      = 1'b0;
    localparam logic REG_HALVING_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [CTX_W-1:0]   ctx_index;
        logic               ctx_negative;
        logic               ctx_zero;
        logic signed [18:0] error_adj;
    } cbc_item_t;

    typedef struct packed {
        logic [16:0] sample_range;
        logic [15:0] halving_threshold;
    } cbc_cfg_t;

    typedef struct packed {
        logic boot_clear;
    } cbc_status_t;

    function automatic logic signed [3:0] quantize(input logic signed [18:0] g);
        logic signed [3:0] q;
        if (g <= -THR_LARGE)      q = -4'sd4;
        else if (g <= -THR_MID)   q = -4'sd3;
        else if (g <= -THR_SMALL) q = -4'sd2;
        else if (g < 19'sd0)      q = -4'sd1;
        else if (g == 19'sd0)     q = 4'sd0;
        else if (g < THR_SMALL)   q = 4'sd1;
        else if (g < THR_MID)     q = 4'sd2;
        else if (g < THR_LARGE)   q = 4'sd3;
        else                      q = 4'sd4;
        return q;
    endfunction

    function automatic logic [INIT_W-1:0] init_error(input logic [16:0] range);
        logic [17:0]        s;
        logic [INIT_W-1:0]  v;
        s = {1'b0, range} + 18'(INIT_ROUND);
        v = s[17:INIT_SHIFT];
        if (v < INIT_W'(INIT_MIN))
            v = INIT_W'(INIT_MIN);
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- src/cbc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface cbc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [17:0] gradient_first;
    logic signed [17:0] gradient_second;
    logic signed [17:0] gradient_third;
    logic signed [17:0] prediction_error;

    modport source (output valid, operation, gradient_first, gradient_second,
                    gradient_third, prediction_error, input ready);
    modport sink (input valid, operation, gradient_first, gradient_second,
                  gradient_third, prediction_error, output ready);
endinterface

interface cbc_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] correction;
    logic [8:0]         context_index;
    logic               context_negative;
    logic [31:0]        error_sum;

    modport source (output valid, correction, context_index, context_negative,
                    error_sum, input ready);
    modport sink (input valid, correction, context_index, context_negative,
                  error_sum, output ready);
endinterface
`default_nettype wire

// ----- src/cbc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbc_front
    import cbc_pkg::*;
(
    cbc_in_if.sink    request,
    input  wire logic q_full,
    input  wire cbc_status_t status,
    output logic      push,
    output cbc_item_t push_item
);

    logic signed [18:0] g1_neg;
    logic signed [18:0] g2_neg;
    logic signed [18:0] g3_neg;
    logic signed [3:0]  q0;
    logic signed [3:0]  q1;
    logic signed [3:0]  q2;
    logic signed [9:0]  cx;
    logic signed [9:0]  cx_mag;
    logic signed [18:0] err_ext;

    // Negate gradients before quantizing
    assign g1_neg = -{request.gradient_first[17], request.gradient_first};
    assign g2_neg = -{request.gradient_second[17], request.gradient_second};
    assign g3_neg = -{request.gradient_third[17], request.gradient_third};

    assign q0 = quantize(g1_neg);
    assign q1 = quantize(g2_neg);
    assign q2 = quantize(g3_neg);

    assign cx = {{6{q0[3]}}, q0}
              + {{6{q1[3]}}, q1} * WEIGHT_SECOND
              + {{6{q2[3]}}, q2} * WEIGHT_THIRD;

    assign cx_mag  = cx[9] ? -cx : cx;
    assign err_ext = {request.prediction_error[17], request.prediction_error};

    always_comb
    begin
        push_item.operation    = request.operation;
        push_item.ctx_index    = cx_mag[CTX_W-1:0];
        push_item.ctx_negative = cx[9];
        push_item.ctx_zero     = (cx == 10'sd0);
        // fold the error sign along with the context sign
        push_item.error_adj    = cx[9] ? -err_ext : err_ext;
    end

    assign request.ready = !q_full && !status.boot_clear;
    assign push          = request.valid && request.ready;

endmodule
`default_nettype wire

// ----- src/cbc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbc_queue
    import cbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cbc_item_t push_item,
    input  wire logic      pop,
    output cbc_item_t      head,
    output logic           full,
    output logic           empty
);

    cbc_item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QFILL_W-1:0]    fill_reg;

    assign full  = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue push while full");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("queue pop while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("queue fill count lost a push");

endmodule
`default_nettype wire

// ----- src/cbc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbc_back
    import cbc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cbc_cfg_t  cfg,
    input  wire cbc_item_t head,
    input  wire logic      q_empty,
    output logic           pop,
    output cbc_status_t    status,
    cbc_out_if.source      result
);

    typedef struct packed {
        logic [31:0]        error_sum;
        logic signed [16:0] bias;
        logic signed [16:0] corr;
        logic [15:0]        count;
    } ctx_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STAT,
        S_FIN,
        S_CLR
    } state_t;

    ctx_entry_t         ctx_mem [CONTEXT_COUNT];
    ctx_entry_t         rd_entry_reg;

    state_t             state_reg;
    cbc_item_t          item_reg;
    logic [CTX_W-1:0]   clr_ptr_reg;
    logic [INIT_W-1:0]  init_reg;
    logic               pending_reg;
    logic               boot_reg;

    logic [31:0]        a_reg;
    logic signed [19:0] bh_reg;
    logic [15:0]        nn_reg;
    logic signed [16:0] c_reg;

    logic               out_valid_reg;
    logic signed [16:0] out_corr_reg;
    logic [CTX_W-1:0]   out_index_reg;
    logic               out_neg_reg;
    logic [31:0]        out_err_reg;

    // statistics stage
    logic [31:0]        a_next;
    logic signed [19:0] bh_next;
    logic [15:0]        nn_next;

    // adjust stage
    logic signed [16:0] c_new;
    logic signed [16:0] b_new;
    logic signed [16:0] corr_res;
    logic [31:0]        err_res;

    logic               slot_free;
    logic               fin_fire;
    logic               is_update;
    logic               mem_we;
    logic [CTX_W-1:0]   mem_waddr;
    ctx_entry_t         mem_wdata;
    ctx_entry_t         wr_entry;

    assign slot_free = !out_valid_reg || result.ready;
    assign fin_fire  = (state_reg == S_FIN) && slot_free;
    assign is_update = (item_reg.operation == OP_UPDATE);
    assign pop       = (state_reg == S_IDLE) && !q_empty;

    assign status.boot_clear = boot_reg;

    always_comb
    begin
        logic [18:0]        abs_e;
        logic [32:0]        a_sum;
        logic [31:0]        a_sat;
        logic signed [19:0] b_sum;
        logic               halve;
        logic [15:0]        n_h;
        abs_e   = item_reg.error_adj[18] ? 19'(-item_reg.error_adj)
                                         : 19'(item_reg.error_adj);
        a_sum   = {1'b0, rd_entry_reg.error_sum} + {14'b0, abs_e};
        a_sat   = a_sum[32] ? 32'hFFFF_FFFF : a_sum[31:0];
        b_sum   = {{3{rd_entry_reg.bias[16]}}, rd_entry_reg.bias}
                + {item_reg.error_adj[18], item_reg.error_adj};
        halve   = (rd_entry_reg.count == cfg.halving_threshold)
               || (rd_entry_reg.count == COUNT_MAX);
        n_h     = halve ? (rd_entry_reg.count >> 1) : rd_entry_reg.count;
        a_next  = is_update ? (halve ? (a_sat >> 1) : a_sat) : rd_entry_reg.error_sum;
        bh_next = halve ? (b_sum >>> 1) : b_sum;
        nn_next = n_h + 16'd1;
    end

    always_comb
    begin
        logic signed [19:0] nn_s;
        logic signed [19:0] b_t;
        logic signed [17:0] half_s;
        logic signed [17:0] c_x;
        logic signed [16:0] corr_base;
        nn_s   = $signed({4'b0, nn_reg});
        half_s = $signed({2'b0, cfg.sample_range[16:1]});
        c_x    = {c_reg[16], c_reg};
        c_new  = c_reg;
        b_t    = bh_reg;
        if (bh_reg <= -nn_s)
        begin
            if (c_x > -half_s)
                c_new = c_reg - 17'sd1;
            b_t = bh_reg + nn_s;
            if (b_t <= -nn_s)
                b_t = 20'sd1 - nn_s;
        end
        else if (bh_reg > 20'sd0)
        begin
            if (c_x < half_s - 18'sd1)
                c_new = c_reg + 17'sd1;
            b_t = bh_reg - nn_s;
            if (b_t > 20'sd0)
                b_t = 20'sd0;
        end
        b_new = b_t[16:0];

        corr_base = is_update ? c_new : c_reg;
        if (item_reg.operation == OP_REINIT)
        begin
            corr_res = 17'sd0;
            err_res  = 32'(init_reg);
        end
        else
        begin
            if (item_reg.ctx_zero)
                corr_res = 17'sd0;
            else if (item_reg.ctx_negative)
                corr_res = -corr_base;
            else
                corr_res = corr_base;
            err_res = a_reg;
        end
    end

    always_comb
    begin
        wr_entry.error_sum = a_reg;
        wr_entry.bias      = b_new;
        wr_entry.corr      = c_new;
        wr_entry.count     = nn_reg;
        if (state_reg == S_CLR)
        begin
            mem_we              = 1'b1;
            mem_waddr           = clr_ptr_reg;
            mem_wdata.error_sum = 32'(init_reg);
            mem_wdata.bias      = 17'sd0;
            mem_wdata.corr      = 17'sd0;
            mem_wdata.count     = 16'd1;
        end
        else
        begin
            mem_we    = fin_fire && is_update;
            mem_waddr = item_reg.ctx_index;
            mem_wdata = wr_entry;
        end
    end

    // context store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ctx_mem[mem_waddr] <= mem_wdata;
        rd_entry_reg <= ctx_mem[head.ctx_index];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head;
        if (state_reg == S_STAT)
        begin
            a_reg  <= a_next;
            bh_reg <= bh_next;
            nn_reg <= nn_next;
            c_reg  <= rd_entry_reg.corr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_ptr_reg   <= '0;
            init_reg      <= init_error(RESET_RANGE);
            pending_reg   <= 1'b0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            out_corr_reg  <= '0;
            out_index_reg <= '0;
            out_neg_reg   <= 1'b0;
            out_err_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.operation == OP_REINIT)
                        begin
                            init_reg    <= init_error(cfg.sample_range);
                            clr_ptr_reg <= '0;
                            pending_reg <= 1'b1;
                            state_reg   <= S_CLR;
                        end
                        else
                            state_reg <= S_STAT;
                    end
                end
                S_STAT:
                    state_reg <= S_FIN;
                S_FIN:
                begin
                    if (slot_free)
                        state_reg <= S_IDLE;
                end
                S_CLR:
                begin
                    if (clr_ptr_reg == CTX_W'(CONTEXT_COUNT - 1))
                    begin
                        pending_reg <= 1'b0;
                        boot_reg    <= 1'b0;
                        state_reg   <= pending_reg ? S_FIN : S_IDLE;
                    end
                    else
                        clr_ptr_reg <= clr_ptr_reg + 1'b1;
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (fin_fire)
            begin
                out_valid_reg <= 1'b1;
                out_corr_reg  <= corr_res;
                out_index_reg <= item_reg.ctx_index;
                out_neg_reg   <= item_reg.ctx_negative;
                out_err_reg   <= err_res;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.correction       = out_corr_reg;
    assign result.context_index    = out_index_reg;
    assign result.context_negative = out_neg_reg;
    assign result.error_sum        = out_err_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
                     (fin_fire && is_update) |-> (wr_entry.count != 16'd0
                                                  && wr_entry.bias <= 17'sd0))
        else $error("context update wrote count zero or positive bias");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_CLR) |-> (clr_ptr_reg <= CTX_W'(CONTEXT_COUNT - 1)))
        else $error("clearing pass ran past the last context");
    assert property (@(posedge clk) disable iff (!rst_n)
                     boot_reg |-> (state_reg == S_CLR && !out_valid_reg))
        else $error("result or item activity during boot clearing pass");

endmodule
`default_nettype wire

// ----- src/context_bias_cancellation_core.sv -----
// Query and update requests: after the store read and the statistics stage, the
// result register loads together with the adjust and write-back of the context
// store; the context engine takes no new request until the last one is through.
// Reinitialize: a clearing pass over all 365 contexts of the store, then the result.
// Reset (rst_n low, asynchronous): registers return to range 256 and threshold 64,
// then a clearing pass over all 365 contexts runs while no request is accepted.
`timescale 1ns / 1ps
`default_nettype none
module context_bias_cancellation_core
    import cbc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    cbc_in_if.sink           request,
    cbc_out_if.source        result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers; the user writes them only while the block is idle (unenforced).
    logic [16:0] sample_range_reg;
    logic [15:0] halving_threshold_reg;
    logic        cfg_write;
    logic        cfg_index;
    cbc_cfg_t    cfg;

    // Front/back coupling through the request queue
    logic        push;
    cbc_item_t   push_item;
    logic        pop;
    cbc_item_t   head;
    logic        q_full;
    logic        q_empty;
    cbc_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // registers sit on 4-byte slots: drop the byte offset
    assign cfg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_range_reg      <= RESET_RANGE;
            halving_threshold_reg <= RESET_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SAMPLE_RANGE:      sample_range_reg      <= pwdata[16:0];
                REG_HALVING_THRESHOLD: halving_threshold_reg <= pwdata[15:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_SAMPLE_RANGE:      prdata = {15'b0, sample_range_reg};
            REG_HALVING_THRESHOLD: prdata = {16'b0, halving_threshold_reg};
            default:               prdata = 32'b0;
        endcase
    end

    assign cfg.sample_range      = sample_range_reg;
    assign cfg.halving_threshold = halving_threshold_reg;

    // Front: accept the request, quantize gradients, fold the context sign.
    cbc_front u_front (
        .request   (request),
        .q_full    (q_full),
        .status    (status),
        .push      (push),
        .push_item (push_item)
    );

    // Short queue: lets the front keep accepting while the back is busy.
    cbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: read-modify-write of the context store, clearing passes, and the
    // output register that holds a result until the sink takes it.
    cbc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .status  (status),
        .result  (result)
    );

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import cbc_pkg::*;

    // Spare operation code: the block treats it as a query.
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Byte addresses of the two configuration registers.
    localparam logic [2:0] ADDR_SAMPLE_RANGE      = {REG_SAMPLE_RANGE, 2'b00};
    localparam logic [2:0] ADDR_HALVING_THRESHOLD = {REG_HALVING_THRESHOLD, 2'b00};

    localparam longint ERROR_SUM_CEILING = 64'h0000_0000_FFFF_FFFF;
    localparam int     POOL_SIZE         = 4;

    typedef struct {
        logic signed [16:0] correction;
        logic [8:0]         context_index;
        logic               context_negative;
        logic [31:0]        error_sum;
    } context_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cbc_in_if  request_if ();
    cbc_out_if result_if ();

    context_bias_cancellation_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the context store and of the two registers.
    logic [31:0] error_sum_model  [CONTEXT_COUNT];
    int          bias_sum_model   [CONTEXT_COUNT];
    int          correction_model [CONTEXT_COUNT];
    int          count_model      [CONTEXT_COUNT];
    logic [16:0] model_range;
    logic [15:0] model_threshold;

    // Results predicted at request acceptance, oldest first.
    context_result_t predicted_context_results[$];

    // Recurring contexts of the current random batch, each with an error drift.
    int pool_gradient [POOL_SIZE][3];
    int pool_drift    [POOL_SIZE];

    bit request_gaps_on;
    bit result_stalls_on;
    int result_hold_cycles;
    int sink_stall_left;

    int mismatch_count;
    int requests_sent;
    int results_checked;
    int settings_applied;
    int reinit_count;

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stop a hung run; the bound covers every stall and clearing pass many times.
    initial
    begin
        #36_000_000;
        $display("[context_bias_cancellation_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int gradient_level(input int g);
        if (g <= -THR_LARGE)      return -4;
        else if (g <= -THR_MID)   return -3;
        else if (g <= -THR_SMALL) return -2;
        else if (g < 0)           return -1;
        else if (g == 0)          return 0;
        else if (g < THR_SMALL)   return 1;
        else if (g < THR_MID)     return 2;
        else if (g < THR_LARGE)   return 3;
        return 4;
    endfunction

    // Clear every context from the current sample range.
    function automatic void clear_context_model();
        int start_sum;
        start_sum = (int'(model_range) + 32) >>> 6;
        if (start_sum < 2)
            start_sum = 2;
        for (int i = 0; i < CONTEXT_COUNT; i++)
        begin
            error_sum_model[i]  = 32'(start_sum);
            bias_sum_model[i]   = 0;
            correction_model[i] = 0;
            count_model[i]      = 1;
        end
    endfunction

    function automatic context_result_t predict_context_access(
        input logic [1:0]         op,
        input logic signed [17:0] g1,
        input logic signed [17:0] g2,
        input logic signed [17:0] g3,
        input logic signed [17:0] err_in
    );
        int              ctx;
        int              idx;
        bit              neg;
        longint          a, b, c, n, half, err, corr;
        context_result_t r;
        ctx = gradient_level(-int'(g1)) + 9 * gradient_level(-int'(g2))
            + 81 * gradient_level(-int'(g3));
        neg = ctx < 0;
        idx = neg ? -ctx : ctx;

        if (op == OP_UPDATE)
        begin
            // Negative contexts accumulate the negated error.
            err  = neg ? -longint'(err_in) : longint'(err_in);
            a    = longint'(error_sum_model[idx]);
            b    = bias_sum_model[idx];
            c    = correction_model[idx];
            n    = count_model[idx];
            half = longint'(model_range >> 1);

            a += (err < 0) ? -err : err;
            if (a > ERROR_SUM_CEILING)
                a = ERROR_SUM_CEILING;
            b += err;

            // Halve at the threshold, and also when the count is full.
            if (n == longint'(model_threshold) || n == longint'(COUNT_MAX))
            begin
                a = a >>> 1;
                n = n >>> 1;
                b = (b >= 0) ? (b >>> 1) : -((1 - b) >>> 1);
            end
            n++;

            if (b <= -n)
            begin
                if (c > -half)
                    c--;
                b += n;
                if (b <= -n)
                    b = 1 - n;
            end
            else if (b > 0)
            begin
                if (c < half - 1)
                    c++;
                b -= n;
                if (b > 0)
                    b = 0;
            end

            error_sum_model[idx]  = a[31:0];
            bias_sum_model[idx]   = int'(b);
            correction_model[idx] = int'(c);
            count_model[idx]      = int'(n);
        end
        else if (op == OP_REINIT)
        begin
            clear_context_model();
        end

        // Context zero always reports no correction.
        if (ctx == 0)
            corr = 0;
        else
            corr = neg ? -longint'(correction_model[idx]) : longint'(correction_model[idx]);

        r.correction       = corr[16:0];
        r.context_index    = 9'(idx);
        r.context_negative = neg;
        r.error_sum        = error_sum_model[idx];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Compare each accepted result against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        context_result_t want;
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (predicted_context_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                want = predicted_context_results.pop_front();
                check_field("correction", result_if.correction, want.correction);
                check_field("context_index", result_if.context_index, want.context_index);
                check_field("context_negative", result_if.context_negative,
                            want.context_negative);
                check_field("error_sum", result_if.error_sum, want.error_sum);
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int pick_gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: random stalls, plus a long hold-off counted here on request.
    initial
    begin
        result_if.ready = 1'b0;
        sink_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (result_hold_cycles > 0)
            begin
                sink_stall_left    = result_hold_cycles;
                result_hold_cycles = 0;
            end
            if (sink_stall_left > 0)
            begin
                result_if.ready <= 1'b0;
                sink_stall_left--;
            end
            else if (result_stalls_on && $urandom_range(0, 9) < 3)
            begin
                result_if.ready <= 1'b0;
                sink_stall_left = pick_gap_length() - 1;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offer one request, hold it until accepted, then predict its result.
    // Without a gap valid stays high into the next request.
    task automatic send_request(input logic [1:0] op, input int g1, input int g2,
                                input int g3, input int err);
        logic signed [17:0] f1, f2, f3, fe;
        int                 gap;
        f1 = 18'(g1);
        f2 = 18'(g2);
        f3 = 18'(g3);
        fe = 18'(err);
        @(negedge clk);
        request_if.valid            <= 1'b1;
        request_if.operation        <= op;
        request_if.gradient_first   <= f1;
        request_if.gradient_second  <= f2;
        request_if.gradient_third   <= f3;
        request_if.prediction_error <= fe;
        @(posedge clk);
        while (request_if.ready !== 1'b1)
            @(posedge clk);
        predicted_context_results.push_back(predict_context_access(op, f1, f2, f3, fe));
        requests_sent++;
        if (op == OP_REINIT)
            reinit_count++;
        if (request_gaps_on && $urandom_range(0, 9) >= 4)
        begin
            gap = pick_gap_length();
            @(negedge clk);
            request_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, wait out every outstanding result, then let the pipe settle.
    task automatic drain_results();
        @(negedge clk);
        request_if.valid <= 1'b0;
        while (predicted_context_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (addr == ADDR_SAMPLE_RANGE)
            model_range = value[16:0];
        else
            model_threshold = value[15:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        check_field($sformatf("register 0x%0h read-back", addr), prdata, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------
    function automatic int boundary_gradient();
        int edges[17] = '{0, 1, -1, 2, -2, 3, -3, 6, -6, 7, -7, 20, -20, 21, -21,
                          65536, -65536};
        return edges[$urandom_range(0, 16)];
    endfunction

    // Mostly near the thresholds, sometimes anywhere in the field.
    function automatic int random_gradient();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, 50) - 25;
        else if (r < 9)
            return boundary_gradient();
        return $urandom_range(0, 131072) - 65536;
    endfunction

    function automatic int random_error(input int drift);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return drift * $urandom_range(1, 16);
        else if (r < 9)
            return $urandom_range(0, 40) - 20;
        return $urandom_range(0, 131072) - 65536;
    endfunction

    // Half the requests revisit a few drifting contexts so that corrections move,
    // halving fires and the clamp is reached; the rest scatter.
    task automatic run_random_requests(input int count);
        logic [1:0] op;
        int         g[3];
        int         drift;
        int         k;
        int         r;
        for (k = 0; k < POOL_SIZE; k++)
        begin
            for (int j = 0; j < 3; j++)
                pool_gradient[k][j] = random_gradient();
            pool_drift[k] = $urandom_range(0, 1) ? 1 : -1;
        end
        repeat (count)
        begin
            if ($urandom_range(0, 1))
            begin
                k     = $urandom_range(0, POOL_SIZE - 1);
                g     = pool_gradient[k];
                drift = pool_drift[k];
            end
            else
            begin
                for (int j = 0; j < 3; j++)
                    g[j] = random_gradient();
                drift = $urandom_range(0, 1) ? 1 : -1;
            end
            r = $urandom_range(0, 99);
            if (r < 68)
                op = OP_UPDATE;
            else if (r < 93)
                op = OP_QUERY;
            else if (r < 97)
                op = OP_SPARE;
            else
                op = OP_REINIT;
            send_request(op, g[0], g[1], g[2], random_error(drift));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Query the store straight after the clearing pass.
    task automatic test_reset_state();
        send_request(OP_QUERY, 0, 0, 0, 0);
        send_request(OP_QUERY, -65536, -65536, -65536, 65536);
        send_request(OP_QUERY, 65536, 65536, 65536, -65536);
        send_request(OP_QUERY, -1, 0, 0, 0);
        send_request(OP_QUERY, 0, 0, 1, 0);
        drain_results();
    endtask

    // Hit both sides of every quantizer threshold.
    task automatic test_quantizer_edges();
        send_request(OP_QUERY, -2, -6, -20, 0);
        send_request(OP_QUERY, -3, -7, -21, 0);
        send_request(OP_QUERY, 2, 6, 20, 0);
        send_request(OP_QUERY, 3, 7, 21, 0);
        send_request(OP_QUERY, 1, -65536, 0, 0);
        drain_results();
    endtask

    // Update both context signs, context zero, extreme errors, spare code, reinit.
    task automatic test_update_paths();
        send_request(OP_UPDATE, -65536, -65536, -65536, 65536);
        send_request(OP_UPDATE, -65536, -65536, -65536, -65536);
        send_request(OP_UPDATE, 65536, 65536, 65536, 65536);
        send_request(OP_UPDATE, 0, 0, 0, 20);
        send_request(OP_UPDATE, 0, 0, 0, 20);
        send_request(OP_QUERY, 0, 0, 0, 0);
        send_request(OP_UPDATE, -1, 0, 0, 5);
        send_request(OP_UPDATE, -1, 0, 0, 5);
        send_request(OP_UPDATE, 1, 0, 0, 5);
        send_request(OP_SPARE, -1, 0, 0, 100);
        send_request(OP_REINIT, 65536, 65536, 65536, 0);
        send_request(OP_QUERY, -65536, -65536, -65536, 0);
        drain_results();
    endtask

    // Walk through register settings, extremes first, with a random batch each.
    task automatic test_register_settings();
        int range_list[4]     = '{2, 65536, 65535, 256};
        int threshold_list[4] = '{2, 65535, 3, 64};
        for (int s = 0; s < 5; s++)
        begin
            drain_results();
            if (s < 4)
            begin
                write_register(ADDR_SAMPLE_RANGE, 32'(range_list[s]));
                write_register(ADDR_HALVING_THRESHOLD, 32'(threshold_list[s]));
            end
            else
            begin
                write_register(ADDR_SAMPLE_RANGE, 32'($urandom_range(2, 65536)));
                write_register(ADDR_HALVING_THRESHOLD, 32'($urandom_range(2, 65535)));
            end
            settings_applied++;
            // Rebuild the store from the new range before the batch.
            send_request(OP_REINIT, random_gradient(), random_gradient(),
                         random_gradient(), 0);
            run_random_requests(210);
        end
        drain_results();
    endtask

    // Hold results off for a long stretch while requests keep coming,
    // so the block fills and stalls its input.
    task automatic test_result_backpressure();
        request_gaps_on    = 1'b0;
        result_hold_cycles = 300;
        run_random_requests(40);
        request_gaps_on = 1'b1;
        drain_results();
    endtask

    // Run with no idling on either side.
    task automatic test_back_to_back();
        request_gaps_on  = 1'b0;
        result_stalls_on = 1'b0;
        run_random_requests(150);
        drain_results();
        request_gaps_on  = 1'b1;
        result_stalls_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                       = 1'b0;
        psel                        = 1'b0;
        penable                     = 1'b0;
        pwrite                      = 1'b0;
        paddr                       = '0;
        pwdata                      = '0;
        request_if.valid            = 1'b0;
        request_if.operation        = OP_QUERY;
        request_if.gradient_first   = '0;
        request_if.gradient_second  = '0;
        request_if.gradient_third   = '0;
        request_if.prediction_error = '0;
        request_gaps_on             = 1'b1;
        result_stalls_on            = 1'b1;
        result_hold_cycles          = 0;
        mismatch_count              = 0;
        requests_sent               = 0;
        results_checked             = 0;
        settings_applied            = 0;
        reinit_count                = 0;
        model_range                 = RESET_RANGE;
        model_threshold             = RESET_THRESHOLD;
        clear_context_model();

        // Hold reset, then release it away from the rising edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_quantizer_edges();
        test_update_paths();
        test_register_settings();
        test_result_backpressure();
        test_back_to_back();

        drain_results();
        repeat (20) @(posedge clk);

        $display("covered %0d requests and %0d results over %0d register settings",
                 requests_sent, results_checked, settings_applied);
        $display("including %0d store reinitializations and a long result hold-off",
                 reinit_count);
        if (mismatch_count == 0)
            $display("[context_bias_cancellation_core] OK");
        else
            $display("[context_bias_cancellation_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cbc_pkg.sv
src/cbc_if.sv
src/cbc_front.sv
src/cbc_queue.sv
src/cbc_back.sv
src/context_bias_cancellation_core.sv
bench/tb.sv
